[src/irqhsr_pkg.sv]
// irqhsr_pkg: shared types and constants for the irq handler slot registry
// payload words, slot record, status and action codes, sequencer states
// no dependencies
package irqhsr_pkg;

	localparam int MAP_SIZE = 8;

	// dynamic line numbers in order of their dynamic index
	localparam logic [7:0] DYN_MAP [MAP_SIZE] = '{
		8'd3, 8'd5, 8'd6, 8'd8, 8'd9, 8'd10, 8'd14, 8'd15
	};

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARANTINE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED    = 2'd1;

	localparam logic [7:0] ALLOWED_RESET = 8'h01;

	localparam logic ACT_REGISTER   = 1'b0;
	localparam logic ACT_UNREGISTER = 1'b1;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_CONTEXT     = 4'd1,
		ST_INVALID     = 4'd2,
		ST_UNSUPPORTED = 4'd3,
		ST_BUSY        = 4'd4,
		ST_EXISTS      = 4'd5,
		ST_SHARE       = 4'd6,
		ST_FULL        = 4'd7,
		ST_NOT_FOUND   = 4'd8
	} status_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  line_number;
		logic [31:0] handler_token;
		logic [31:0] argument_token;
		logic [7:0]  request_flags;
		logic        from_interrupt;
	} in_word_t;

	typedef struct packed {
		status_t    status;
		logic [1:0] slot_index;
	} out_word_t;

	typedef struct packed {
		logic        shared;
		logic [31:0] argument;
		logic [31:0] handler;
	} slot_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SCAN,
		CS_DECIDE,
		CS_MOVE_RD,
		CS_MOVE_WR,
		CS_DONE
	} ctrl_state_t;

endpackage

[src/irqhsr_slot_mem.sv]
// irqhsr_slot_mem: slot record memory, one write port and one read port
// read data registered, valid in the cycle after the read; uses irqhsr_pkg
module irqhsr_slot_mem
	import irqhsr_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  slot_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output slot_t         rdata
);

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/irqhsr_precheck.sv]
// irqhsr_precheck: request checks that need no slot contents
// context, range, line decode, null handler, flags, quarantine; uses irqhsr_pkg
module irqhsr_precheck
	import irqhsr_pkg::*;
#(
	parameter int EFF_LINES  = 8,
	parameter int DW         = 3,
	parameter int LINE_LIMIT = 16
) (
	input  in_word_t      req,
	input  logic [7:0]    quarantine_mask,
	input  logic [7:0]    allowed_flags,
	output logic          pass,
	output status_t       status,
	output logic [DW-1:0] dyn
);

	logic       hit;
	logic       range_bad;
	logic [2:0] qidx;

	always_comb begin
		hit = 1'b0;
		dyn = '0;
		for (int i = 0; i < EFF_LINES; i++) begin
			if (!hit && req.line_number == DYN_MAP[i]) begin
				hit = 1'b1;
				dyn = DW'(i);
			end
		end
	end

	assign range_bad = {1'b0, req.line_number} >= 9'(LINE_LIMIT);
	assign qidx      = 3'(dyn);

	always_comb begin
		status = ST_OK;
		if (req.from_interrupt) begin
			status = ST_CONTEXT;
		end else if (range_bad) begin
			status = ST_INVALID;
		end else if (!hit) begin
			status = ST_UNSUPPORTED;
		end else if (req.handler_token == '0) begin
			status = ST_INVALID;
		end else if (req.action == ACT_REGISTER) begin
			// unregister ignores flags and quarantine
			if ((req.request_flags & ~allowed_flags) != '0) begin
				status = ST_INVALID;
			end else if (quarantine_mask[qidx]) begin
				status = ST_BUSY;
			end
		end
	end

	assign pass = (status == ST_OK);

endmodule

[src/irqhsr_ctrl.sv]
// irqhsr_ctrl: request sequencer, fill counts and slot scan / compaction
// drives the slot memory ports; uses irqhsr_pkg
module irqhsr_ctrl
	import irqhsr_pkg::*;
#(
	parameter int EFF_LINES      = 8,
	parameter int SLOTS_PER_LINE = 4,
	parameter int DW             = 3,
	parameter int SW             = 2,
	parameter int FW             = 3,
	parameter int AW             = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  in_word_t      req,
	input  logic          pre_pass,
	input  status_t       pre_status,
	input  logic [DW-1:0] pre_dyn,
	input  logic          out_free,
	output logic          done_fire,
	output out_word_t     result,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output slot_t         mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  slot_t         mem_rdata
);

	ctrl_state_t state_q, state_d;

	logic [FW-1:0] line_fill_q [EFF_LINES];

	in_word_t      req_q;
	logic [DW-1:0] d_q;
	logic [FW-1:0] n_q;
	logic [FW-1:0] iss_q;
	logic          rd_vld_s1;
	logic [SW-1:0] idx_s1;
	logic          found_q;
	logic [SW-1:0] k_q;
	logic          all_shared_q;
	logic [SW-1:0] mv_q;
	status_t       status_q;
	logic [SW-1:0] slot_q;

	logic accept;
	logic issue;
	logic match;
	logic share_bad;
	logic more_move;
	logic last_move;
	int   base;

	assign accept    = in_valid && in_ready;
	assign base      = int'(d_q) * SLOTS_PER_LINE;
	assign issue     = (state_q == CS_SCAN) && (iss_q < n_q);
	assign match     = rd_vld_s1 && mem_rdata.handler == req_q.handler_token
		&& mem_rdata.argument == req_q.argument_token;
	assign share_bad = (n_q != '0) && (!req_q.request_flags[0] || !all_shared_q);
	assign more_move = int'(k_q) + 1 < int'(n_q);
	assign last_move = int'(mv_q) + 2 >= int'(n_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					state_d = pre_pass ? CS_SCAN : CS_DONE;
				end
			end
			CS_SCAN: begin
				if (!issue && !rd_vld_s1) begin
					state_d = CS_DECIDE;
				end
			end
			CS_DECIDE: begin
				if (req_q.action == ACT_UNREGISTER && found_q && more_move) begin
					state_d = CS_MOVE_RD;
				end else begin
					state_d = CS_DONE;
				end
			end
			CS_MOVE_RD: state_d = CS_MOVE_WR;
			CS_MOVE_WR: state_d = last_move ? CS_DONE : CS_MOVE_RD;
			CS_DONE: begin
				if (out_free) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// outputs and memory ports; reads and writes never touch one entry in one cycle
	always_comb begin
		in_ready  = 1'b0;
		done_fire = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = AW'(base + int'(iss_q));
		mem_we    = 1'b0;
		mem_waddr = AW'(base + int'(n_q));
		mem_wdata = '{shared: req_q.request_flags[0], argument: req_q.argument_token,
			handler: req_q.handler_token};
		unique case (state_q)
			CS_IDLE: in_ready = 1'b1;
			CS_SCAN: mem_re = issue;
			CS_DECIDE: begin
				mem_we = (req_q.action == ACT_REGISTER) && !found_q && !share_bad
					&& (int'(n_q) < SLOTS_PER_LINE);
			end
			CS_MOVE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(base + int'(mv_q) + 1);
			end
			CS_MOVE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(base + int'(mv_q));
				mem_wdata = mem_rdata;
			end
			CS_DONE: done_fire = out_free;
			default: ;
		endcase
	end

	assign result = '{status: status_q, slot_index: 2'(slot_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CS_IDLE;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			all_shared_q <= 1'b1;
			iss_q        <= '0;
			status_q     <= ST_OK;
			slot_q       <= '0;
			for (int i = 0; i < EFF_LINES; i++) begin
				line_fill_q[i] <= '0;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				found_q      <= 1'b0;
				all_shared_q <= 1'b1;
				iss_q        <= '0;
				status_q     <= pre_status;
				slot_q       <= '0;
			end
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (match && !found_q) begin
					found_q <= 1'b1;
				end
				if (!mem_rdata.shared) begin
					all_shared_q <= 1'b0;
				end
			end
			if (state_q == CS_DECIDE) begin
				if (req_q.action == ACT_REGISTER) begin
					if (found_q) begin
						status_q <= ST_EXISTS;
					end else if (share_bad) begin
						status_q <= ST_SHARE;
					end else if (int'(n_q) >= SLOTS_PER_LINE) begin
						status_q <= ST_FULL;
					end else begin
						status_q        <= ST_OK;
						slot_q          <= SW'(n_q);
						line_fill_q[d_q] <= n_q + 1'b1;
					end
				end else if (!found_q) begin
					status_q <= ST_NOT_FOUND;
				end else begin
					status_q        <= ST_OK;
					slot_q          <= k_q;
					line_fill_q[d_q] <= n_q - 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			d_q   <= pre_dyn;
			n_q   <= line_fill_q[pre_dyn];
		end
		idx_s1 <= iss_q[SW-1:0];
		if (rd_vld_s1 && match && !found_q) begin
			k_q <= idx_s1;
		end
		if (state_q == CS_DECIDE) begin
			mv_q <= k_q;
		end else if (state_q == CS_MOVE_WR) begin
			mv_q <= mv_q + 1'b1;
		end
	end

endmodule

[src/irq_handler_slot_registry.sv]
// irq_handler_slot_registry: top level of the shared interrupt handler table
// holds the configuration registers and the result register
// uses irqhsr_pkg, irqhsr_precheck, irqhsr_ctrl, irqhsr_slot_mem
//
// channels: req (in_valid/in_ready) carries one register or unregister word,
// res (out_valid/out_ready) returns one status word per request, and
// cfg (cfg_valid/cfg_ready, always ready) writes quarantine_mask (index 0)
// or allowed_flags (index 1); other indices are ignored.
// one request is worked at a time; in_ready is high only while idle.
// a request refused by the early checks skips the slot scan and goes straight to the done state.
// otherwise, with n the line's fill count and k the matching slot, the request
// scans the n filled slots, then decides, and on unregister moves each of the
// n - k - 1 later entries down one slot. the scan uses the single read port
// of the slot memory, walked one slot a cycle, and each compaction move is a
// read then a write.
// reset empties every line (fill counts zero), clears quarantine_mask and sets
// allowed_flags to 1; slot contents need no clearing.
// a stalled result waits in the output register; the next request is taken
// meanwhile and held at its end until the register frees.
module irq_handler_slot_registry
	import irqhsr_pkg::*;
#(
	parameter int DYN_LINES      = 8,
	parameter int SLOTS_PER_LINE = 4,
	parameter int LINE_LIMIT     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int EFF_LINES = (DYN_LINES < MAP_SIZE) ? DYN_LINES : MAP_SIZE;
	localparam int DEPTH     = EFF_LINES * SLOTS_PER_LINE;
	localparam int DW        = (EFF_LINES > 1) ? $clog2(EFF_LINES) : 1;
	localparam int SW        = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
	localparam int FW        = $clog2(SLOTS_PER_LINE + 1);
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] quarantine_mask_q;
	logic [7:0] allowed_flags_q;

	logic          pre_pass;
	status_t       pre_status;
	logic [DW-1:0] pre_dyn;

	logic      out_valid_q;
	out_word_t out_q;
	logic      out_free;
	logic      done_fire;
	out_word_t result;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	slot_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	slot_t         mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarantine_mask_q <= '0;
			allowed_flags_q   <= ALLOWED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_QUARANTINE: quarantine_mask_q <= cfg_data;
				CFG_ALLOWED:    allowed_flags_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	irqhsr_precheck #(
		.EFF_LINES  (EFF_LINES),
		.DW         (DW),
		.LINE_LIMIT (LINE_LIMIT)
	) u_precheck (
		.req             (req),
		.quarantine_mask (quarantine_mask_q),
		.allowed_flags   (allowed_flags_q),
		.pass            (pre_pass),
		.status          (pre_status),
		.dyn             (pre_dyn)
	);

	irqhsr_ctrl #(
		.EFF_LINES      (EFF_LINES),
		.SLOTS_PER_LINE (SLOTS_PER_LINE),
		.DW             (DW),
		.SW             (SW),
		.FW             (FW),
		.AW             (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req        (req),
		.pre_pass   (pre_pass),
		.pre_status (pre_status),
		.pre_dyn    (pre_dyn),
		.out_free   (out_free),
		.done_fire  (done_fire),
		.result     (result),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	irqhsr_slot_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output word register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |-> (!out_valid_q || out_ready))
		else $error("result loaded over a word not yet taken");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while another is in work");

	a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res.status != ST_OK) |-> res.slot_index == 2'd0)
		else $error("slot index set on a refused request");

	a_no_write_while_read_same: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> mem_waddr != mem_raddr)
		else $error("slot memory read and write collide");

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for irq_handler_slot_registry
// drives register and unregister words against an in-bench model of the slot table
// depends on irqhsr_pkg and the irq_handler_slot_registry rtl
module tb_top;
	import irqhsr_pkg::*;

	localparam int DYN_LINES      = 8;
	localparam int SLOTS_PER_LINE = 4;
	localparam int LINE_LIMIT     = 16;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 135;
	localparam int CYCLE_LIMIT    = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// model of the handler table, with the queue of status words still owed
	class slot_table_board;
		logic [31:0] handler_at [DYN_LINES*SLOTS_PER_LINE];
		logic [31:0] argument_at [DYN_LINES*SLOTS_PER_LINE];
		logic        shared_at [DYN_LINES*SLOTS_PER_LINE];
		int          fill [DYN_LINES];
		logic [7:0]  quarantine;
		logic [7:0]  allowed;
		out_word_t   owed_status [$];
		int          mismatches;

		function new();
			foreach (fill[i]) fill[i] = 0;
			quarantine = 8'h00;
			allowed    = ALLOWED_RESET;
			mismatches = 0;
		endfunction

		function int pending();
			return owed_status.size();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
			if (idx == CFG_QUARANTINE) begin
				quarantine = data;
			end else if (idx == CFG_ALLOWED) begin
				allowed = data;
			end
		endfunction

		// works out the status word of one accepted request and updates the table
		function void note_request(in_word_t w);
			status_t    st;
			logic [1:0] slot;
			int         d;
			int         base;
			int         n;
			int         k;
			out_word_t  word;
			st   = ST_OK;
			slot = 2'd0;
			d    = -1;
			k    = -1;
			if (w.from_interrupt) begin
				st = ST_CONTEXT;
			end else if (w.line_number >= LINE_LIMIT) begin
				st = ST_INVALID;
			end else begin
				for (int i = 0; i < DYN_LINES; i++) begin
					if (d < 0 && DYN_MAP[i] == w.line_number) d = i;
				end
				if (d < 0) begin
					st = ST_UNSUPPORTED;
				end else if (w.handler_token == 32'd0) begin
					st = ST_INVALID;
				end
			end
			if (st == ST_OK) begin
				base = d * SLOTS_PER_LINE;
				n    = fill[d];
				for (int i = 0; i < n; i++) begin
					if (k < 0 && handler_at[base+i] == w.handler_token
							&& argument_at[base+i] == w.argument_token) k = i;
				end
				if (w.action == ACT_REGISTER) begin
					if ((w.request_flags & ~allowed) != 8'd0) begin
						st = ST_INVALID;
					end else if (quarantine[d]) begin
						st = ST_BUSY;
					end else if (k >= 0) begin
						st = ST_EXISTS;
					end else begin
						if (n > 0) begin
							if (!w.request_flags[0]) st = ST_SHARE;
							for (int i = 0; i < n; i++) begin
								if (!shared_at[base+i]) st = ST_SHARE;
							end
						end
						if (st == ST_OK && n >= SLOTS_PER_LINE) st = ST_FULL;
						if (st == ST_OK) begin
							handler_at[base+n]  = w.handler_token;
							argument_at[base+n] = w.argument_token;
							shared_at[base+n]   = w.request_flags[0];
							fill[d]             = n + 1;
							slot                = n[1:0];
						end
					end
				end else if (k < 0) begin
					st = ST_NOT_FOUND;
				end else begin
					// close the gap left by the removed entry
					for (int i = k; i + 1 < n; i++) begin
						handler_at[base+i]  = handler_at[base+i+1];
						argument_at[base+i] = argument_at[base+i+1];
						shared_at[base+i]   = shared_at[base+i+1];
					end
					handler_at[base+n-1]  = 32'd0;
					argument_at[base+n-1] = 32'd0;
					shared_at[base+n-1]   = 1'b0;
					fill[d]               = n - 1;
					slot                  = k[1:0];
				end
			end
			word.status     = st;
			word.slot_index = slot;
			owed_status.push_back(word);
		endfunction

		function void check_response(out_word_t got);
			out_word_t want;
			if (owed_status.size() == 0) begin
				$error("status word with nothing owed: status %0d slot_index %0d",
					got.status, got.slot_index);
				mismatches++;
				return;
			end
			want = owed_status.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.slot_index !== want.slot_index) begin
				$error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_word_t             req       = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_QUARANTINE;
	logic [7:0]           cfg_data  = 8'h00;

	slot_table_board board = new();
	bit              calm  = 1'b0;
	int              cycle_count = 0;
	logic [7:0]      quarantine_plan [PHASES];
	logic [7:0]      allowed_plan [PHASES];

	irq_handler_slot_registry #(
		.DYN_LINES      (DYN_LINES),
		.SLOTS_PER_LINE (SLOTS_PER_LINE),
		.LINE_LIMIT     (LINE_LIMIT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.note_request(req);
			if (out_valid && out_ready) board.check_response(res);
			if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
		end
	end

	// result side back-pressure in bursts
	initial begin
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic push_request(input logic act, input logic [7:0] line,
			input logic [31:0] h, input logic [31:0] a, input logic [7:0] f,
			input logic ctx);
		in_word_t w;
		w.action         = act;
		w.line_number    = line;
		w.handler_token  = h;
		w.argument_token = a;
		w.request_flags  = f;
		w.from_interrupt = ctx;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req      <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// let every owed word come back before touching the registers
	// the first wait lets the last accepted word reach the board
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_request();
		logic        act;
		logic        ctx;
		logic [7:0]  line;
		logic [7:0]  f;
		logic [31:0] h;
		logic [31:0] a;
		int          d;
		int          j;
		if ($urandom_range(0, 99) < 12) begin
			// noise: any value of any field
			act  = 1'($urandom);
			line = 8'($urandom);
			h    = $urandom;
			a    = $urandom;
			f    = 8'($urandom);
			ctx  = 1'($urandom);
		end else begin
			ctx  = 1'b0;
			act  = ($urandom_range(0, 99) < 55) ? ACT_REGISTER : ACT_UNREGISTER;
			d    = $urandom_range(0, MAP_SIZE - 1);
			line = DYN_MAP[d];
			h    = $urandom_range(1, 6);
			a    = $urandom_range(0, 3);
			if ($urandom_range(0, 49) == 0) h = 32'd0;
			if ($urandom_range(0, 29) == 0) begin
				line = 8'($urandom_range(0, LINE_LIMIT - 1));
				d    = -1;
			end
			f    = 8'($urandom);
			f    = f & board.allowed;
			f[0] = board.allowed[0] && ($urandom_range(0, 9) < 8);
			if ($urandom_range(0, 19) == 0) f = 8'($urandom);
			// mostly remove something that is actually there
			if (act == ACT_UNREGISTER && d >= 0 && board.fill[d] > 0
					&& $urandom_range(0, 3) != 0) begin
				j = $urandom_range(0, board.fill[d] - 1);
				h = board.handler_at[d*SLOTS_PER_LINE+j];
				a = board.argument_at[d*SLOTS_PER_LINE+j];
			end
		end
		push_request(act, line, h, a, f, ctx);
	endtask

	initial begin
		quarantine_plan = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'h81, 8'h00, 8'h00};
		allowed_plan    = '{8'h01, 8'hFF, 8'h00, 8'hFF, 8'h03, 8'h00, 8'h01, 8'h01};
		quarantine_plan[6] = 8'($urandom);
		allowed_plan[6]    = 8'($urandom);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: no quarantine, only the share bit legal
		push_request(ACT_REGISTER,   8'd3,   32'd1, 32'd0, 8'h01, 1'b1);
		push_request(ACT_UNREGISTER, 8'd3,   32'd1, 32'd0, 8'h01, 1'b1);
		push_request(ACT_REGISTER,   8'hFF,  32'd1, 32'd0, 8'h01, 1'b0);
		push_request(ACT_REGISTER,   8'd16,  32'd1, 32'd0, 8'h01, 1'b0);
		push_request(ACT_REGISTER,   8'd0,   32'd1, 32'd0, 8'h01, 1'b0);
		push_request(ACT_UNREGISTER, 8'd13,  32'd1, 32'd0, 8'h00, 1'b0);
		push_request(ACT_REGISTER,   8'd3,   32'd0, 32'd0, 8'h01, 1'b0);
		push_request(ACT_UNREGISTER, 8'd3,   32'd0, 32'd0, 8'h00, 1'b0);
		push_request(ACT_REGISTER,   8'd3,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h02, 1'b0);
		// a private handler locks the line against sharing
		push_request(ACT_REGISTER,   8'd3,   32'd1, 32'd0, 8'h00, 1'b0);
		push_request(ACT_REGISTER,   8'd3,   32'd1, 32'd0, 8'h01, 1'b0);
		push_request(ACT_REGISTER,   8'd3,   32'd2, 32'd0, 8'h01, 1'b0);
		push_request(ACT_UNREGISTER, 8'd3,   32'd7, 32'd0, 8'h00, 1'b0);
		push_request(ACT_UNREGISTER, 8'd3,   32'd1, 32'd0, 8'h00, 1'b0);
		// fill line 15, overflow it, then remove from the middle
		for (int i = 0; i < SLOTS_PER_LINE; i++) begin
			push_request(ACT_REGISTER, 8'd15, 32'hFFFF_FFFF, i, 8'h01, 1'b0);
		end
		push_request(ACT_REGISTER,   8'd15,  32'h8000_0000, 32'd0, 8'h01, 1'b0);
		push_request(ACT_REGISTER,   8'd15,  32'd5, 32'd0, 8'h00, 1'b0);
		push_request(ACT_UNREGISTER, 8'd15,  32'hFFFF_FFFF, 32'd1, 8'h00, 1'b0);
		push_request(ACT_UNREGISTER, 8'd15,  32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b0);
		settle();

		write_register(CFG_QUARANTINE, 8'h42);
		write_register(CFG_ALLOWED, 8'h03);
		write_register(CFG_SPARE, 8'($urandom));
		push_request(ACT_REGISTER,   8'd5,   32'd9, 32'd0, 8'h03, 1'b0);
		push_request(ACT_REGISTER,   8'd14,  32'hFFFF_FFFF, 32'd0, 8'h03, 1'b0);
		// unregister on line 15, which lies outside the quarantine mask
		push_request(ACT_UNREGISTER, 8'd15,  32'hFFFF_FFFF, 32'd3, 8'h00, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_register(CFG_QUARANTINE, quarantine_plan[p]);
			write_register(CFG_ALLOWED, allowed_plan[p]);
			if (p == PHASES - 1) calm = 1'b1;
			repeat (PHASE_WORDS) random_request();
		end
		settle();

		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

[irq_handler_slot_registry.f]
src/irqhsr_pkg.sv
src/irqhsr_slot_mem.sv
src/irqhsr_precheck.sv
src/irqhsr_ctrl.sv
src/irq_handler_slot_registry.sv
bench/tb_top.sv
